// ===== src/tkpc_pkg.sv =====
`timescale 1ns / 1ps
package tkpc_pkg;

  localparam int unsigned AddrW = 5;
  localparam int unsigned DataW = 32;
  localparam int unsigned TimerW = 15;

  localparam logic [2:0] RegShort = 3'd0;
  localparam logic [2:0] RegLong = 3'd1;
  localparam logic [2:0] RegRelease = 3'd2;
  localparam logic [2:0] RegDoubleHit = 3'd3;
  localparam logic [2:0] RegGap = 3'd4;

  localparam logic [7:0] ShortReset = 8'd3;
  localparam logic [7:0] LongReset = 8'd80;
  localparam logic [7:0] ReleaseReset = 8'd3;
  localparam logic [7:0] DoubleHitReset = 8'd20;
  localparam logic [7:0] GapReset = 8'd10;

  localparam logic [2:0] NoKeyScan = 3'd7;
  localparam logic [2:0] NoKeyCode = 3'd7;
  localparam logic [2:0] MaxKeyCode = 3'd5;
  localparam logic [7:0] CountMax = 8'd255;

  localparam logic OpTick = 1'b0;
  localparam logic OpLed = 1'b1;

  typedef struct packed {
    logic [7:0] short_press_ticks;
    logic [7:0] long_press_ticks;
    logic [7:0] release_ticks;
    logic [7:0] double_hit_ticks;
    logic [7:0] report_gap_ticks;
  } cfg_t;

  typedef struct packed {
    logic       key_valid;
    logic [2:0] key_code;
    logic       long_press;
    logic       led_on;
  } res_t;

  function automatic logic [2:0] code_of_scan(input logic [2:0] scan);
    logic [2:0] code;
    case (scan)
      3'd1: code = 3'd5;
      3'd2: code = 3'd3;
      3'd3: code = 3'd2;
      3'd4: code = 3'd4;
      3'd5: code = 3'd0;
      3'd6: code = 3'd1;
      default: code = NoKeyCode;
    endcase
    return code;
  endfunction

endpackage

// ===== src/tkpc_cfg.sv =====
`timescale 1ns / 1ps
module tkpc_cfg (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       psel_i,
  input  logic                       penable_i,
  input  logic                       pwrite_i,
  input  logic [tkpc_pkg::AddrW-1:0] paddr_i,
  input  logic [tkpc_pkg::DataW-1:0] pwdata_i,
  output logic [tkpc_pkg::DataW-1:0] prdata_o,
  output logic                       pready_o,
  output tkpc_pkg::cfg_t             cfg_o
);

  tkpc_pkg::cfg_t cfg_q;
  logic [2:0]     index;
  logic           wr_en;
  logic [7:0]     rd_val;

  assign index    = paddr_i[tkpc_pkg::AddrW-1:2];
  assign pready_o = 1'b1;
  assign wr_en    = psel_i & penable_i & pwrite_i & pready_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.short_press_ticks <= tkpc_pkg::ShortReset;
      cfg_q.long_press_ticks  <= tkpc_pkg::LongReset;
      cfg_q.release_ticks     <= tkpc_pkg::ReleaseReset;
      cfg_q.double_hit_ticks  <= tkpc_pkg::DoubleHitReset;
      cfg_q.report_gap_ticks  <= tkpc_pkg::GapReset;
    end else if (wr_en) begin
      case (index)
        tkpc_pkg::RegShort:     cfg_q.short_press_ticks <= pwdata_i[7:0];
        tkpc_pkg::RegLong:      cfg_q.long_press_ticks  <= pwdata_i[7:0];
        tkpc_pkg::RegRelease:   cfg_q.release_ticks     <= pwdata_i[7:0];
        tkpc_pkg::RegDoubleHit: cfg_q.double_hit_ticks  <= pwdata_i[7:0];
        tkpc_pkg::RegGap:       cfg_q.report_gap_ticks  <= pwdata_i[7:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (index)
      tkpc_pkg::RegShort:     rd_val = cfg_q.short_press_ticks;
      tkpc_pkg::RegLong:      rd_val = cfg_q.long_press_ticks;
      tkpc_pkg::RegRelease:   rd_val = cfg_q.release_ticks;
      tkpc_pkg::RegDoubleHit: rd_val = cfg_q.double_hit_ticks;
      tkpc_pkg::RegGap:       rd_val = cfg_q.report_gap_ticks;
      default:                rd_val = 8'd0;
    endcase
  end

  assign prdata_o = {{(tkpc_pkg::DataW-8){1'b0}}, rd_val};
  assign cfg_o    = cfg_q;

endmodule

// ===== src/tkpc_core.sv =====
`timescale 1ns / 1ps
module tkpc_core #(
  parameter int unsigned LED_TICKS_PER_SECOND = 100
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           step_i,
  input  logic           operation_i,
  input  logic [2:0]     pins_i,
  input  logic [7:0]     led_seconds_i,
  input  tkpc_pkg::cfg_t cfg_i,
  output tkpc_pkg::res_t res_o
);

  localparam int unsigned TW = tkpc_pkg::TimerW;

  logic [7:0]    press_count_q, press_count_d;
  logic [7:0]    release_count_q, release_count_d;
  logic [7:0]    holdoff_count_q, holdoff_count_d;
  logic [7:0]    gap_count_q, gap_count_d;
  logic [2:0]    sample0_q, sample0_d;
  logic [2:0]    sample1_q, sample1_d;
  logic [TW-1:0] led_timer_q, led_timer_d;
  logic          led_lit_q, led_lit_d;
  logic [2:0]    key;
  logic [TW-1:0] led_product;

  assign led_product = TW'(led_seconds_i) * TW'(LED_TICKS_PER_SECOND);
  assign key         = tkpc_pkg::code_of_scan(sample1_q);

  always_comb begin
    press_count_d   = press_count_q;
    release_count_d = release_count_q;
    holdoff_count_d = holdoff_count_q;
    gap_count_d     = gap_count_q;
    sample0_d       = sample0_q;
    sample1_d       = sample1_q;
    led_timer_d     = led_timer_q;
    led_lit_d       = led_lit_q;
    res_o           = '0;

    if (operation_i == tkpc_pkg::OpLed) begin
      led_timer_d = led_product;
      led_lit_d   = 1'b1;
    end else begin
      if (gap_count_q != 8'd0) begin
        gap_count_d = gap_count_q - 8'd1;
      end
      if (led_timer_q != '0) begin
        led_timer_d = led_timer_q - TW'(1);
        if (led_timer_d == '0) begin
          led_lit_d = 1'b0;
        end
      end
      if (pins_i != tkpc_pkg::NoKeyScan) begin
        if (press_count_q != tkpc_pkg::CountMax) begin
          press_count_d = press_count_q + 8'd1;
        end
        release_count_d = 8'd0;
        if (press_count_d == 8'd1) begin
          sample0_d = pins_i;
        end else if (press_count_d == 8'd2) begin
          sample1_d = pins_i;
          if (sample0_q != pins_i) begin
            sample0_d     = pins_i;
            press_count_d = 8'd1;
          end
        end else if (press_count_d == 8'd3) begin
          if (sample1_q != pins_i) begin
            sample0_d     = pins_i;
            press_count_d = 8'd1;
          end
        end else if (sample0_q != pins_i) begin
          sample0_d     = pins_i;
          press_count_d = 8'd1;
        end else if (press_count_d > cfg_i.long_press_ticks) begin
          press_count_d = cfg_i.long_press_ticks;
        end
      end else begin
        if (release_count_q != tkpc_pkg::CountMax) begin
          release_count_d = release_count_q + 8'd1;
        end
        if (release_count_d >= cfg_i.release_ticks) begin
          release_count_d = cfg_i.release_ticks;
          if (holdoff_count_q != 8'd0) begin
            holdoff_count_d = holdoff_count_q - 8'd1;
            press_count_d   = 8'd0;
          end else if (press_count_q >= cfg_i.short_press_ticks) begin
            if (key != tkpc_pkg::NoKeyCode) begin
              if (gap_count_d == 8'd0) begin
                res_o.key_valid  = 1'b1;
                res_o.key_code   = key;
                res_o.long_press = (press_count_q == cfg_i.long_press_ticks);
                gap_count_d      = cfg_i.report_gap_ticks;
              end
              holdoff_count_d = cfg_i.double_hit_ticks;
            end
            press_count_d = 8'd0;
          end
        end
      end
    end
    res_o.led_on = led_lit_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      press_count_q   <= 8'd0;
      release_count_q <= 8'd0;
      holdoff_count_q <= 8'd0;
      gap_count_q     <= 8'd0;
      sample0_q       <= 3'd0;
      sample1_q       <= 3'd0;
      led_timer_q     <= '0;
      led_lit_q       <= 1'b0;
    end else if (step_i) begin
      press_count_q   <= press_count_d;
      release_count_q <= release_count_d;
      holdoff_count_q <= holdoff_count_d;
      gap_count_q     <= gap_count_d;
      sample0_q       <= sample0_d;
      sample1_q       <= sample1_d;
      led_timer_q     <= led_timer_d;
      led_lit_q       <= led_lit_d;
    end
  end

  a_gap_loaded: assert property (@(posedge clk_i) disable iff (!rst_ni)
    step_i && res_o.key_valid |=> gap_count_q == $past(cfg_i.report_gap_ticks))
    else $error("gap timer not loaded after report");

  a_press_cleared: assert property (@(posedge clk_i) disable iff (!rst_ni)
    step_i && res_o.key_valid |=> press_count_q == 8'd0)
    else $error("press counter not cleared after report");

  a_code_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    step_i && res_o.key_valid |-> res_o.key_code <= tkpc_pkg::MaxKeyCode)
    else $error("reported key code out of range");

endmodule

// ===== src/touch_key_press_classifier_top.sv =====
`timescale 1ns / 1ps
// channel   direction  handshake                 payload
// in        input      in_valid_i / in_stall_o   operation_i, pins_i, led_seconds_i
// out       output     out_valid_o / out_stall_i key_valid_o, key_code_o, long_press_o,
//                                                 led_on_o
// cfg       input      apb psel/penable/pwrite   paddr, pwdata, prdata
//
// one request per cycle sustained while out_stall_i is low
// request sits in the input register, is classified and lands in the result register
// counters update in the classify step, so back-to-back requests chain in order
// out_stall_i holds the result register, then the input register, then in_stall_o
// reset clears all counters, the led timer and the valid flags, and loads cfg defaults
module touch_key_press_classifier_top #(
  parameter int unsigned LED_TICKS_PER_SECOND = 100
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       in_valid_i,
  output logic                       in_stall_o,
  input  logic                       operation_i,
  input  logic [2:0]                 pins_i,
  input  logic [7:0]                 led_seconds_i,
  output logic                       out_valid_o,
  input  logic                       out_stall_i,
  output logic                       key_valid_o,
  output logic [2:0]                 key_code_o,
  output logic                       long_press_o,
  output logic                       led_on_o,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [tkpc_pkg::AddrW-1:0] paddr,
  input  logic [tkpc_pkg::DataW-1:0] pwdata,
  output logic [tkpc_pkg::DataW-1:0] prdata,
  output logic                       pready
);

  tkpc_pkg::cfg_t cfg;
  tkpc_pkg::res_t res;
  tkpc_pkg::res_t res_q;

  logic       in_vld_q, in_vld_d;
  logic       out_vld_q, out_vld_d;
  logic       op_q;
  logic [2:0] pins_q;
  logic [7:0] secs_q;
  logic       out_free;
  logic       move;
  logic       in_take;

  assign out_free   = !out_vld_q || !out_stall_i;
  assign move       = in_vld_q && out_free;
  assign in_stall_o = in_vld_q && !out_free;
  assign in_take    = in_valid_i && !in_stall_o;

  tkpc_cfg u_cfg (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .psel_i    (psel),
    .penable_i (penable),
    .pwrite_i  (pwrite),
    .paddr_i   (paddr),
    .pwdata_i  (pwdata),
    .prdata_o  (prdata),
    .pready_o  (pready),
    .cfg_o     (cfg)
  );

  tkpc_core #(
    .LED_TICKS_PER_SECOND (LED_TICKS_PER_SECOND)
  ) u_core (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .step_i        (move),
    .operation_i   (op_q),
    .pins_i        (pins_q),
    .led_seconds_i (secs_q),
    .cfg_i         (cfg),
    .res_o         (res)
  );

  always_comb begin
    in_vld_d = in_vld_q;
    if (in_take) begin
      in_vld_d = 1'b1;
    end else if (move) begin
      in_vld_d = 1'b0;
    end
    out_vld_d = out_vld_q;
    if (move) begin
      out_vld_d = 1'b1;
    end else if (!out_stall_i) begin
      out_vld_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q  <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      in_vld_q  <= in_vld_d;
      out_vld_q <= out_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_take) begin
      op_q   <= operation_i;
      pins_q <= pins_i;
      secs_q <= led_seconds_i;
    end
    if (move) begin
      res_q <= res;
    end
  end

  assign out_valid_o  = out_vld_q;
  assign key_valid_o  = res_q.key_valid;
  assign key_code_o   = res_q.key_code;
  assign long_press_o = res_q.long_press;
  assign led_on_o     = res_q.led_on;

  a_stall_held: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> in_vld_q && out_vld_q)
    else $error("input stalled without a held request");

endmodule
